### rtl/evo_pkg.sv
// evo_pkg: shared types, constants and helper functions of the EVENODD recovery block
// used by every module under rtl
`default_nettype none
package evo_pkg;

    localparam int NUM_DISKS   = 7;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_EQS     = 8;
    localparam int PRIME       = 5;
    localparam int DATA_BITS   = 32;
    localparam int WORD_BITS_D = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic CFG_ERASED_A = 1'b0;
    localparam logic CFG_ERASED_B = 1'b1;

    typedef struct packed {
        logic [DATA_BITS-1:0] word_disk0;
        logic [DATA_BITS-1:0] word_disk1;
        logic [DATA_BITS-1:0] word_disk2;
        logic [DATA_BITS-1:0] word_disk3;
        logic [DATA_BITS-1:0] word_disk4;
        logic [DATA_BITS-1:0] word_disk5;
        logic [DATA_BITS-1:0] word_disk6;
    } in_t;

    typedef struct packed {
        logic [2:0]           disk_index;
        logic [1:0]           row_in_block;
        logic [DATA_BITS-1:0] recovered_word;
        logic                 last_of_block;
    } out_t;

    typedef struct packed {
        logic            ok;
        logic [7:0][7:0] m;
    } solve_t;

    // does cell (disk, row) take part in equation eq
    function automatic logic evo_in_eq(input logic [2:0] eq, input logic [2:0] disk,
                                       input logic [1:0] row);
        int i;
        int d;
        int r;
        int t;
        logic res;
        d = int'(disk);
        r = int'(row);
        res = 1'b0;
        if (eq < 3'd4)
        begin
            res = (d <= 5) && (r == int'(eq));
        end
        else
        begin
            i = int'(eq) - 4;
            // diagonal index wraps once at most
            t = i + PRIME - r;
            if (t >= PRIME)
                t = t - PRIME;
            if (d == 6)
                res = (r == i);
            else if (d > 4)
                res = 1'b0;
            else
                res = (d == 4 - r) || (d == t);
        end
        return res;
    endfunction

    // gauss-jordan on the 8x8 system, returns the inverse rows
    function automatic solve_t evo_solve(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] coef [8];
        logic [7:0] aug  [8];
        logic [7:0] tc;
        logic [7:0] ta;
        int p;
        solve_t s;
        s.ok = (lo != hi) && (lo <= 3'd6) && (hi <= 3'd6);
        for (int e = 0; e < NUM_EQS; e++)
        begin
            coef[e] = '0;
            aug[e]  = 8'(1 << e);
            for (int k = 0; k < NUM_EQS; k++)
                coef[e][k] = evo_in_eq(3'(e), (k < 4) ? lo : hi, 2'(k));
        end
        for (int c = 0; c < NUM_EQS; c++)
        begin
            if (s.ok)
            begin
                p = NUM_EQS;
                for (int r = NUM_EQS - 1; r >= 0; r--)
                    if (r >= c && coef[r][c])
                        p = r;
                if (p == NUM_EQS)
                begin
                    s.ok = 1'b0;
                end
                else
                begin
                    tc = coef[p]; ta = aug[p];
                    coef[p] = coef[c]; aug[p] = aug[c];
                    coef[c] = tc; aug[c] = ta;
                    for (int r = 0; r < NUM_EQS; r++)
                        if (r != c && coef[r][c])
                        begin
                            coef[r] = coef[r] ^ coef[c];
                            aug[r]  = aug[r] ^ aug[c];
                        end
                end
            end
        end
        for (int k = 0; k < NUM_EQS; k++)
            s.m[k] = aug[k];
        return s;
    endfunction

endpackage
`default_nettype wire

### rtl/evo_queue.sv
// evo_queue: short block queue between the syndrome front and the solve back
// depends on evo_pkg for the depth
`default_nettype none
module evo_queue
    import evo_pkg::*;
#(
    parameter int ENTRY_BITS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic [ENTRY_BITS-1:0] push_data,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       nonempty,
    output logic [ENTRY_BITS-1:0]      head
);
    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    logic [ENTRY_BITS-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [PTR_BITS:0]     count_reg, count_next;

    assign full     = (count_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
            wptr_next = (wptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        if (pop)
            rptr_next = (rptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

### rtl/evo_front.sv
// evo_front: takes stripe rows and folds known words into the eight syndromes
// depends on evo_pkg; hands finished blocks to evo_queue
`default_nettype none
module evo_front
    import evo_pkg::*;
#(
    parameter int SYN_BITS = WORD_BITS_D
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_t                   in_data,
    input  wire logic [2:0]            erased_a,
    input  wire logic [2:0]            erased_b,
    input  wire logic                  q_full,
    output logic                       push,
    output logic [6+8*SYN_BITS-1:0]    push_data
);
    logic [SYN_BITS-1:0] sum_reg [NUM_EQS];
    logic [SYN_BITS-1:0] sum_next [NUM_EQS];
    logic [SYN_BITS-1:0] words [NUM_DISKS];
    logic [SYN_BITS-1:0] acc;
    logic [1:0]          row_reg;
    logic                accept;
    logic [2:0]          lo, hi;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && (row_reg == 2'd3);
    assign lo       = (erased_a < erased_b) ? erased_a : erased_b;
    assign hi       = (erased_a < erased_b) ? erased_b : erased_a;

    always_comb
    begin
        words[0] = in_data.word_disk0[SYN_BITS-1:0];
        words[1] = in_data.word_disk1[SYN_BITS-1:0];
        words[2] = in_data.word_disk2[SYN_BITS-1:0];
        words[3] = in_data.word_disk3[SYN_BITS-1:0];
        words[4] = in_data.word_disk4[SYN_BITS-1:0];
        words[5] = in_data.word_disk5[SYN_BITS-1:0];
        words[6] = in_data.word_disk6[SYN_BITS-1:0];
        for (int e = 0; e < NUM_EQS; e++)
        begin
            acc = sum_reg[e];
            for (int d = 0; d < NUM_DISKS; d++)
                if (3'(d) != erased_a && 3'(d) != erased_b && evo_in_eq(3'(e), 3'(d), row_reg))
                    acc = acc ^ words[d];
            sum_next[e] = acc;
        end
        push_data[6+8*SYN_BITS-1 -: 3] = lo;
        push_data[3+8*SYN_BITS-1 -: 3] = hi;
        for (int e = 0; e < NUM_EQS; e++)
            push_data[e*SYN_BITS +: SYN_BITS] = sum_next[e];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            for (int e = 0; e < NUM_EQS; e++)
                sum_reg[e] <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_reg + 1'b1;
            for (int e = 0; e < NUM_EQS; e++)
                sum_reg[e] <= push ? '0 : sum_next[e];
        end
    end

endmodule
`default_nettype wire

### rtl/evo_back.sv
// evo_back: applies the solved inverse to a queued block, one word per unstalled cycle
// depends on evo_pkg for the solver and result type
`default_nettype none
module evo_back
    import evo_pkg::*;
#(
    parameter int SYN_BITS = WORD_BITS_D
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [2:0]            erased_a,
    input  wire logic [2:0]            erased_b,
    input  wire logic                  q_nonempty,
    input  wire logic [6+8*SYN_BITS-1:0] q_head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_t                       out_data
);
    solve_t              inv_reg;
    logic [2:0]          k_reg;
    logic                valid_reg;
    out_t                data_reg, data_next;
    logic                advance;
    logic [SYN_BITS-1:0] w;

    assign advance   = q_nonempty && (!valid_reg || !out_stall);
    assign pop       = advance && (k_reg == 3'd7);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        w = '0;
        for (int j = 0; j < NUM_EQS; j++)
            if (inv_reg.m[k_reg][j])
                w = w ^ q_head[j*SYN_BITS +: SYN_BITS];
        data_next.disk_index     = k_reg[2] ? q_head[3+8*SYN_BITS-1 -: 3]
                                            : q_head[6+8*SYN_BITS-1 -: 3];
        data_next.row_in_block   = k_reg[1:0];
        data_next.recovered_word = inv_reg.ok ? DATA_BITS'(w) : '0;
        data_next.last_of_block  = (k_reg == 3'd7);
    end

    // inverse follows erasure registers; user must change them only while idle, unenforced
    always_ff @(posedge clk)
    begin
        inv_reg <= evo_solve((erased_a < erased_b) ? erased_a : erased_b,
                             (erased_a < erased_b) ? erased_b : erased_a);
        if (advance)
            data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                k_reg     <= k_reg + 1'b1;
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/evodd_two_erasure_recovery.sv
// evenodd_two_erasure_recovery: top level with the erasure registers and the three parts
// depends on evo_pkg, evo_front, evo_queue, evo_back
`default_nettype none
// Recovers two erased disks of a seven-disk EVENODD array (p = 5) four rows at a time.
// Rows are taken one per cycle while the two-block queue has room; after every fourth
// row eight recovered words come out, one per cycle while out_stall is low, lower erased
// disk first, rows 0-3. The sustained rate is set by the back part emitting the eight
// words of a block at one per cycle. Erasure indices must be written through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
module evenodd_two_erasure_recovery
    import evo_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_D
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [2:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_t        in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_t            out_data
);
    localparam int SYN_BITS   = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;
    localparam int ENTRY_BITS = 6 + 8 * SYN_BITS;

    logic [2:0]            erased_a_reg, erased_b_reg;
    logic                  push, pop, q_full, q_nonempty;
    logic [ENTRY_BITS-1:0] push_data, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erased_a_reg <= 3'd0;
            erased_b_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ERASED_A: erased_a_reg <= cfg_data;
                CFG_ERASED_B: erased_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    evo_front #(.SYN_BITS(SYN_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .erased_a  (erased_a_reg),
        .erased_b  (erased_b_reg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    evo_queue #(.ENTRY_BITS(ENTRY_BITS)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    evo_back #(.SYN_BITS(SYN_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .erased_a   (erased_a_reg),
        .erased_b   (erased_b_reg),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
`default_nettype wire
